FILE: rtl/core/keyed_service_table_unit_assert.svh
// Assertion macros shared by the table RTL.
`ifndef KEYED_SERVICE_TABLE_UNIT_ASSERT_SVH
`define KEYED_SERVICE_TABLE_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define KST_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/kst_pkg.sv
package kst_pkg;

   localparam int TABLE_DEPTH_DEF  = 16;
   localparam int PAYLOAD_BITS_DEF = 32;

   localparam logic [2:0] OP_UPDATE    = 3'd0;
   localparam logic [2:0] OP_REMOVE    = 3'd1;
   localparam logic [2:0] OP_FIND_ID   = 3'd2;
   localparam logic [2:0] OP_FIND_CHAN = 3'd3;
   localparam logic [2:0] OP_READ_POS  = 3'd4;
   localparam logic [2:0] OP_CLEAR     = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_REJECTED  = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_FETCH,
      ST_LATCH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic        entry_valid;
      logic [15:0] service_key;
      logic [15:0] major_number;
      logic [15:0] minor_number;
      logic [31:0] payload_in;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_key;
      logic [15:0] found_major;
      logic [15:0] found_minor;
      logic [31:0] found_payload;
      logic [6:0]  live_count;
      logic        changed;
   } rsp_type;

endpackage

FILE: rtl/core/keyed_service_table_unit.sv
// Channel    | Ports                          | Handshake
// request    | start, busy, req_item          | taken when start is high and busy is low
// response   | rsp_strobe, rsp_item           | one cycle per request, cannot be held off
//
// Every request gives one response. Clear, unused codes and requests refused at
// once go straight to ST_FINISH; a read by position passes ST_FETCH and ST_LATCH
// first. Lookups, updates and removes walk the live entries in turn through the
// single read port of the entry memory with one shared comparator in ST_SCAN. An
// update then writes its slot in ST_WRITE; a remove that hits below the last live
// entry moves that entry into the hole through ST_MOVE_RD and ST_MOVE_WR.
// Synchronous reset empties the table at once; busy is low after reset.
// The receiver cannot stall; busy stays high until the response strobe.
module keyed_service_table_unit #(
   parameter int TABLE_DEPTH  = kst_pkg::TABLE_DEPTH_DEF,
   parameter int PAYLOAD_BITS = kst_pkg::PAYLOAD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kst_pkg::req_type req_item,
   output logic             rsp_strobe,
   output kst_pkg::rsp_type rsp_item
);
   import kst_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   typedef struct packed {
      logic [15:0]             key;
      logic [15:0]             major;
      logic [15:0]             minor;
      logic [PAYLOAD_BITS-1:0] payload;
   } slot_type;

   slot_type mem [TABLE_DEPTH];

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_strobe_ff;
   rsp_type          rsp_item_ff;

   req_type          req_ff;
   logic [1:0]       status_ff;
   slot_type         found_ff;
   logic             changed_ff;
   logic [CNT_W-1:0] scan_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   slot_type         rd_data_ff;

   logic             accept;
   logic             issue;
   logic             scan_hit;
   logic             scan_miss;
   logic [31:0]      cmp_lhs, cmp_rhs;
   logic             room;
   logic             update_bad;
   logic             pos_ok;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;
   slot_type         req_slot;
   logic [CNT_W-1:0] count_dec;
   logic [PAYLOAD_BITS+31:0] pay_wide_in;
   logic [PAYLOAD_BITS+31:0] pay_wide_out;

   assign accept     = start && (state_ff == ST_IDLE);
   assign issue      = (state_ff == ST_SCAN) && (scan_ff < count_ff);
   assign room       = count_ff < DEPTH_C;
   assign update_bad = !req_item.entry_valid || (req_item.service_key == 16'd0);
   assign pos_ok     = {1'b0, req_item.position} < 9'(count_ff);
   assign count_dec  = count_ff - CNT_W'(1);

   // One comparator serves every search: by id, or by the channel pair.
   always_comb begin
      if (req_ff.operation == OP_FIND_CHAN) begin
         cmp_lhs = {rd_data_ff.major, rd_data_ff.minor};
         cmp_rhs = {req_ff.major_number, req_ff.minor_number};
      end else begin
         cmp_lhs = {16'd0, rd_data_ff.key};
         cmp_rhs = {16'd0, req_ff.service_key};
      end
   end

   assign scan_hit  = (state_ff == ST_SCAN) && pend_ff && (cmp_lhs == cmp_rhs);
   assign scan_miss = (state_ff == ST_SCAN) && !pend_ff && !issue;

   assign pay_wide_in   = {PAYLOAD_BITS'(0), req_ff.payload_in};
   assign req_slot.key     = req_ff.service_key;
   assign req_slot.major   = req_ff.major_number;
   assign req_slot.minor   = req_ff.minor_number;
   assign req_slot.payload = pay_wide_in[PAYLOAD_BITS-1:0];
   assign pay_wide_out  = {32'd0, found_ff.payload};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_item.operation == OP_UPDATE) begin
                  state_in = update_bad ? ST_FINISH : ST_SCAN;
               end else if (req_item.operation == OP_REMOVE ||
                            req_item.operation == OP_FIND_ID ||
                            req_item.operation == OP_FIND_CHAN) begin
                  state_in = ST_SCAN;
               end else if (req_item.operation == OP_READ_POS && pos_ok) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               if (req_ff.operation == OP_UPDATE) begin
                  state_in = ST_WRITE;
               end else if (req_ff.operation == OP_REMOVE &&
                            CNT_W'(pend_idx_ff) < count_dec) begin
                  state_in = ST_MOVE_RD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (scan_miss) begin
               if (req_ff.operation == OP_UPDATE && room) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WRITE:   state_in = ST_FINISH;
         ST_MOVE_RD: state_in = ST_MOVE_WR;
         ST_MOVE_WR: state_in = ST_FINISH;
         ST_FETCH:   state_in = ST_LATCH;
         ST_LATCH:   state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory port controls and handshake output.
   always_comb begin
      busy    = (state_ff != ST_IDLE);
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = req_slot;
      unique case (state_ff)
         ST_IDLE:    rd_addr = req_item.position[IDX_W-1:0];
         ST_SCAN:    rd_addr = scan_ff[IDX_W-1:0];
         ST_WRITE:   wr_en   = 1'b1;
         ST_MOVE_RD: rd_addr = count_ff[IDX_W-1:0];
         ST_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
         end
         ST_FETCH:   rd_addr = req_ff.position[IDX_W-1:0];
         ST_LATCH:   rd_addr = req_ff.position[IDX_W-1:0];
         ST_FINISH:  rd_addr = scan_ff[IDX_W-1:0];
         default:    rd_addr = scan_ff[IDX_W-1:0];
      endcase
   end

   // Live entries stay packed at positions below the count.
   always_comb begin
      count_in = count_ff;
      if (accept && req_item.operation == OP_CLEAR) begin
         count_in = '0;
      end else if (scan_hit && req_ff.operation == OP_REMOVE) begin
         count_in = count_dec;
      end else if (scan_miss && req_ff.operation == OP_UPDATE && room) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= (state_ff == ST_FINISH);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      pend_ff     <= issue;
      pend_idx_ff <= scan_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_ff     <= req_item;
               found_ff   <= '0;
               changed_ff <= 1'b0;
               scan_ff    <= '0;
               status_ff  <= STATUS_OK;
               if (req_item.operation == OP_UPDATE && update_bad) begin
                  status_ff <= STATUS_REJECTED;
               end else if (req_item.operation == OP_READ_POS && !pos_ok) begin
                  status_ff <= STATUS_NOT_FOUND;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_ff <= scan_ff + CNT_W'(1);
            end
            if (scan_hit) begin
               found_ff   <= rd_data_ff;
               hit_idx_ff <= pend_idx_ff;
               if (req_ff.operation == OP_REMOVE) begin
                  changed_ff <= 1'b1;
               end
            end else if (scan_miss) begin
               hit_idx_ff <= count_ff[IDX_W-1:0];
               if (req_ff.operation != OP_UPDATE) begin
                  status_ff <= STATUS_NOT_FOUND;
               end else if (!room) begin
                  status_ff <= STATUS_FULL;
               end
            end
         end
         ST_WRITE: begin
            found_ff   <= req_slot;
            changed_ff <= 1'b1;
         end
         ST_LATCH: found_ff <= rd_data_ff;
         ST_FINISH: begin
            rsp_item_ff.status        <= status_ff;
            rsp_item_ff.found_key     <= found_ff.key;
            rsp_item_ff.found_major   <= found_ff.major;
            rsp_item_ff.found_minor   <= found_ff.minor;
            rsp_item_ff.found_payload <= pay_wide_out[31:0];
            rsp_item_ff.live_count    <= 7'(count_ff);
            rsp_item_ff.changed       <= changed_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`include "keyed_service_table_unit_assert.svh"

   `KST_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C, "live count above table depth")
   `KST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe, "accepted request did not hold busy")
   `KST_ASSERT_NEXT(a_finish_strobe, clock, reset, state_ff == ST_FINISH, rsp_strobe && !busy, "response strobe missing after finish")
   `KST_ASSERT_ALWAYS(a_move_target, clock, reset, (state_ff != ST_MOVE_WR) || (CNT_W'(hit_idx_ff) < count_ff), "moved entry lands outside the live range")

endmodule

FILE: tb/keyed_service_table_unit_tb.sv
`timescale 1ns / 1ps

module keyed_service_table_unit_tb;
   import kst_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int RANDOM_REQUESTS = 450;
   localparam int DRAIN_CYCLES = 30;

   // Operation codes that the block ignores.
   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_type;

   typedef struct {
      bit      fixed;
      rsp_type value;
   } typed_result_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Shadow copy of the service table.
   bit          slot_used [DEPTH];
   logic [15:0] slot_id [DEPTH];
   logic [15:0] slot_major [DEPTH];
   logic [15:0] slot_minor [DEPTH];
   logic [31:0] slot_data [DEPTH];
   int          live_total;

   rsp_type          expected_q[$];
   typed_result_type hint_q[$];
   rsp_type          predicted_rsp;
   rsp_type          want_rsp;
   typed_result_type hint;
   int               mismatch_count;
   bit               no_idle;

   keyed_service_table_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("keyed_service_table_unit regression: fail");
      $finish;
   end

   function automatic void append_expected(input rsp_type v);
      expected_q = {expected_q, v};
   endfunction

   function automatic void append_hint(input typed_result_type h);
      hint_q = {hint_q, h};
   endfunction

   function automatic req_type mk_req(input logic [2:0] op, input logic valid,
                                      input logic [15:0] key, input logic [15:0] major,
                                      input logic [15:0] minor, input logic [31:0] payload,
                                      input logic [7:0] pos);
      req_type r;
      r.operation    = op;
      r.entry_valid  = valid;
      r.service_key  = key;
      r.major_number = major;
      r.minor_number = minor;
      r.payload_in   = payload;
      r.position     = pos;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0] status, input logic [15:0] key,
                                      input logic [15:0] major, input logic [15:0] minor,
                                      input logic [31:0] payload, input logic [6:0] count,
                                      input logic changed);
      rsp_type r;
      r.status        = status;
      r.found_key     = key;
      r.found_major   = major;
      r.found_minor   = minor;
      r.found_payload = payload;
      r.live_count    = count;
      r.changed       = changed;
      return r;
   endfunction

   function automatic void report_slot(inout rsp_type res, input int idx);
      res.found_key     = slot_id[idx];
      res.found_major   = slot_major[idx];
      res.found_minor   = slot_minor[idx];
      res.found_payload = slot_data[idx];
   endfunction

   // Applies one request to the shadow table and returns the response it must give.
   function automatic rsp_type apply_request(input req_type r);
      rsp_type res;
      int      hit;
      int      last;
      int      i;
      res = '0;
      res.status = STATUS_OK;
      hit = -1;
      case (r.operation)
         OP_UPDATE: begin
            if (!r.entry_valid || r.service_key == 16'd0) begin
               res.status = STATUS_REJECTED;
            end else begin
               for (i = 0; i < DEPTH; i++)
                  if (hit < 0 && slot_used[i] && slot_id[i] == r.service_key) hit = i;
               for (i = 0; i < DEPTH; i++)
                  if (hit < 0 && !slot_used[i]) hit = i;
               if (hit < 0) begin
                  res.status = STATUS_FULL;
               end else begin
                  if (!slot_used[hit]) live_total++;
                  slot_used[hit]  = 1'b1;
                  slot_id[hit]    = r.service_key;
                  slot_major[hit] = r.major_number;
                  slot_minor[hit] = r.minor_number;
                  slot_data[hit]  = r.payload_in;
                  report_slot(res, hit);
                  res.changed = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            for (i = 0; i < live_total; i++)
               if (hit < 0 && slot_used[i] && slot_id[i] == r.service_key) hit = i;
            if (hit < 0) begin
               res.status = STATUS_NOT_FOUND;
            end else begin
               last = live_total - 1;
               report_slot(res, hit);
               // The last live entry fills the hole so the table stays packed.
               if (hit < last) begin
                  slot_used[hit]  = slot_used[last];
                  slot_id[hit]    = slot_id[last];
                  slot_major[hit] = slot_major[last];
                  slot_minor[hit] = slot_minor[last];
                  slot_data[hit]  = slot_data[last];
               end
               slot_used[last] = 1'b0;
               live_total--;
               res.changed = 1'b1;
            end
         end
         OP_FIND_ID: begin
            for (i = 0; i < live_total; i++)
               if (hit < 0 && slot_used[i] && slot_id[i] == r.service_key) hit = i;
            if (hit < 0) res.status = STATUS_NOT_FOUND;
            else report_slot(res, hit);
         end
         OP_FIND_CHAN: begin
            for (i = 0; i < live_total; i++)
               if (hit < 0 && slot_used[i] && slot_major[i] == r.major_number &&
                   slot_minor[i] == r.minor_number) hit = i;
            if (hit < 0) res.status = STATUS_NOT_FOUND;
            else report_slot(res, hit);
         end
         OP_READ_POS: begin
            if (int'(r.position) < live_total) report_slot(res, int'(r.position));
            else res.status = STATUS_NOT_FOUND;
         end
         OP_CLEAR: begin
            for (i = 0; i < DEPTH; i++) begin
               slot_used[i] = 1'b0;
               slot_id[i]   = 16'd0;
            end
            live_total = 0;
         end
         default: ;
      endcase
      res.live_count = 7'(live_total);
      return res;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Responses are checked before a request taken at the same edge is predicted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with none expected: got %h", $time, rsp_item);
               mismatch_count++;
            end else begin
               want_rsp = expected_q.pop_front();
               compare_field("status", 32'(want_rsp.status), 32'(rsp_item.status));
               compare_field("found_key", 32'(want_rsp.found_key),
                             32'(rsp_item.found_key));
               compare_field("found_major", 32'(want_rsp.found_major),
                             32'(rsp_item.found_major));
               compare_field("found_minor", 32'(want_rsp.found_minor),
                             32'(rsp_item.found_minor));
               compare_field("found_payload", want_rsp.found_payload,
                             rsp_item.found_payload);
               compare_field("live_count", 32'(want_rsp.live_count),
                             32'(rsp_item.live_count));
               compare_field("changed", 32'(want_rsp.changed), 32'(rsp_item.changed));
            end
         end
         if (start && !busy) begin
            predicted_rsp = apply_request(req_item);
            hint = hint_q.pop_front();
            append_expected(hint.fixed ? hint.value : predicted_rsp);
         end
      end
   end

   task automatic issue_request(input req_type r, input bit fixed, input rsp_type value);
      int unsigned gap_len;
      int unsigned roll;
      typed_result_type h;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 45) gap_len = 0;
      else if (roll < 80) gap_len = $urandom_range(1, 3);
      else if (roll < 96) gap_len = $urandom_range(4, 12);
      else gap_len = $urandom_range(20, 60);
      if (gap_len != 0) begin
         start <= 1'b0;
         repeat (gap_len) @(posedge clock);
      end
      h.fixed = fixed;
      h.value = value;
      append_hint(h);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
   endtask

   initial begin
      req_type          rows_req[$];
      typed_result_type rows_rsp[$];
      req_type          r;
      rsp_type          none;
      logic [15:0]      key_pool [24];
      logic [15:0]      chan_major [5];
      logic [15:0]      chan_minor [5];
      traffic_mix_type  mix;
      int               phase_left;
      int unsigned      roll;
      int unsigned      pick;
      none = '0;
      mismatch_count = 0;
      live_total = 0;
      no_idle = 1'b0;
      mix = MIX_FILL;
      phase_left = 0;
      for (int i = 0; i < DEPTH; i++) begin
         slot_used[i]  = 1'b0;
         slot_id[i]    = 16'd0;
         slot_major[i] = 16'd0;
         slot_minor[i] = 16'd0;
         slot_data[i]  = 32'd0;
      end
      foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 65535));
      foreach (chan_major[i]) begin
         chan_major[i] = 16'($urandom);
         chan_minor[i] = 16'($urandom);
      end

      // Directed table: a row with fixed set carries its response typed in.
      rows_req = '{
         mk_req(OP_FIND_ID,   1'b1, 16'h1234, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_UPDATE,    1'b0, 16'h0005, 16'h0011, 16'h0022, 32'hDEAD_BEEF, 8'h00),
         mk_req(OP_UPDATE,    1'b1, 16'h0000, 16'h0011, 16'h0022, 32'h1234_5678, 8'h00),
         mk_req(OP_UPDATE,    1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF),
         mk_req(OP_UPDATE,    1'b1, 16'h0001, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_UPDATE,    1'b1, 16'hFFFF, 16'h8000, 16'h0001, 32'h8000_0001, 8'h00),
         mk_req(OP_UPDATE,    1'b1, 16'h8000, 16'h0000, 16'h0000, 32'h5A5A_5A5A, 8'h00),
         mk_req(OP_FIND_CHAN, 1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_FIND_CHAN, 1'b1, 16'h0000, 16'h1234, 16'h5678, 32'h0000_0000, 8'h00),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'hFF),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h03),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h02),
         mk_req(OP_REMOVE,    1'b1, 16'hFFFF, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_FIND_ID,   1'b1, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_REMOVE,    1'b1, 16'h7777, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_REMOVE,    1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_FIND_ID,   1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_UNUSED_LO, 1'b0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_UNUSED_HI, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF),
         mk_req(OP_REMOVE,    1'b1, 16'h8000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_CLEAR,     1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF),
         mk_req(OP_FIND_ID,   1'b1, 16'h0001, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00),
         mk_req(OP_READ_POS,  1'b1, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 8'h00)
      };
      rows_rsp = '{
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_REJECTED, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_REJECTED, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'd1, 1'b1)},
         '{1'b1, mk_rsp(STATUS_OK, 16'h0001, 16'h0, 16'h0, 32'h0, 7'd2, 1'b1)},
         '{1'b1, mk_rsp(STATUS_OK, 16'hFFFF, 16'h8000, 16'h0001, 32'h8000_0001, 7'd2, 1'b1)},
         '{1'b0, none},
         '{1'b0, none},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd3, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd3, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd3, 1'b0)},
         '{1'b0, none},
         '{1'b0, none},
         '{1'b0, none},
         '{1'b0, none},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd2, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd2, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd2, 1'b0)},
         '{1'b1, mk_rsp(STATUS_OK, 16'h0, 16'h0, 16'h0, 32'h0, 7'd2, 1'b0)},
         '{1'b1, mk_rsp(STATUS_OK, 16'h0, 16'h0, 16'h0, 32'h0, 7'd2, 1'b0)},
         '{1'b0, none},
         '{1'b1, mk_rsp(STATUS_OK, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)},
         '{1'b1, mk_rsp(STATUS_NOT_FOUND, 16'h0, 16'h0, 16'h0, 32'h0, 7'd0, 1'b0)}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows_req[i]) issue_request(rows_req[i], rows_rsp[i].fixed, rows_rsp[i].value);

      // Random traffic in phases that fill, churn or drain the table.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (phase_left == 0) begin
            mix = traffic_mix_type'($urandom_range(0, 2));
            phase_left = $urandom_range(15, 45);
            no_idle = ($urandom_range(0, 3) == 0);
         end
         phase_left--;

         r.entry_valid  = ($urandom_range(0, 19) != 0);
         r.payload_in   = $urandom;
         pick = $urandom_range(0, 4);
         if ($urandom_range(0, 9) < 7) begin
            r.major_number = chan_major[pick];
            r.minor_number = chan_minor[pick];
         end else begin
            r.major_number = 16'($urandom);
            r.minor_number = 16'($urandom);
         end
         roll = $urandom_range(0, 99);
         if (live_total > 0 && roll < 45) r.service_key = slot_id[$urandom_range(0, live_total - 1)];
         else if (roll < 85) r.service_key = key_pool[$urandom_range(0, 23)];
         else if (roll < 97) r.service_key = 16'($urandom);
         else r.service_key = 16'd0;
         if ($urandom_range(0, 9) < 7) r.position = 8'($urandom_range(0, live_total + 1));
         else r.position = 8'($urandom_range(0, 255));

         roll = $urandom_range(0, 99);
         case (mix)
            MIX_FILL: begin
               if (roll < 70) r.operation = OP_UPDATE;
               else if (roll < 78) r.operation = OP_REMOVE;
               else if (roll < 86) r.operation = OP_FIND_ID;
               else if (roll < 92) r.operation = OP_FIND_CHAN;
               else if (roll < 98) r.operation = OP_READ_POS;
               else r.operation = OP_CLEAR;
            end
            MIX_BALANCED: begin
               if (roll < 30) r.operation = OP_UPDATE;
               else if (roll < 50) r.operation = OP_REMOVE;
               else if (roll < 65) r.operation = OP_FIND_ID;
               else if (roll < 80) r.operation = OP_FIND_CHAN;
               else if (roll < 95) r.operation = OP_READ_POS;
               else r.operation = 3'($urandom_range(OP_CLEAR, OP_UNUSED_HI));
            end
            default: begin
               if (roll < 10) r.operation = OP_UPDATE;
               else if (roll < 60) r.operation = OP_REMOVE;
               else if (roll < 75) r.operation = OP_FIND_ID;
               else if (roll < 85) r.operation = OP_FIND_CHAN;
               else if (roll < 98) r.operation = OP_READ_POS;
               else r.operation = ($urandom_range(0, 1) != 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
            end
         endcase

         // Channel lookups mostly aim at a pair that is in the table.
         if (r.operation == OP_FIND_CHAN && live_total > 0 && $urandom_range(0, 9) < 6) begin
            pick = $urandom_range(0, live_total - 1);
            r.major_number = slot_major[pick];
            r.minor_number = slot_minor[pick];
         end

         issue_request(r, 1'b0, none);
      end

      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("keyed_service_table_unit regression: pass");
      end else begin
         $display("keyed_service_table_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/keyed_service_table_unit.sv
tb/keyed_service_table_unit_tb.sv
